@@ rtl/core/next_lexicographic_permutation_defines.svh @@
// Assertion helpers for the checker file.
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_DEFINES_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define NLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define NLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/nlp_pkg.sv @@
`timescale 1ns / 1ps

package nlp_pkg;

    localparam int LEN_W          = 5;
    localparam int POS_W          = 4;
    localparam int DATA_W         = 16;
    localparam int ADDR_W         = 3;
    localparam int APB_DATA_W     = 32;
    localparam int DEF_MAX_LEN    = 16;
    localparam int DEF_VALUE_BITS = 16;

    // Register index, taken from paddr above the byte offset.
    localparam logic [ADDR_W-3:0] REG_PERM_LENGTH = '0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_SCAN2_INIT,
        ST_SCAN2,
        ST_SWAP_P,
        ST_SWAP_Q,
        ST_REV_RD_I,
        ST_REV_RD_J,
        ST_REV_WR_I,
        ST_REV_WR_J,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT,
        ST_DONE_WAIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SCAN_INIT,
        DP_STEP1,
        DP_STEP2,
        DP_WR_P,
        DP_WR_Q,
        DP_RD_I,
        DP_RD_J,
        DP_WR_I,
        DP_WR_J,
        DP_EMIT_INIT,
        DP_EMIT_RD,
        DP_EMIT_LD,
        DP_DONE
    } dp_op_t;

    typedef struct packed {
        logic len_le1;
        logic s1_found;
        logic s1_exhaust;
        logic s2_found;
        logic rev_more;
        logic out_last_taken;
        logic out_more_taken;
    } dp_status_t;

endpackage

@@ rtl/core/next_lexicographic_permutation.sv @@
`timescale 1ns / 1ps
// Next lexicographic permutation engine.
// Input channel (s_*): a request with s_req_type 0 writes s_elem_value at
// s_elem_index (ignored at or beyond perm_length) and gives no result; a
// request with s_req_type 1 steps the stored sequence to its next permutation.
// Result channel (m_*): one result per element in position order, m_last on
// the final one; with no successor (or length 0 or 1) a single result with
// m_no_next and m_last set and the store left as it was.
// perm_length is written over the APB port at address 0; the user must write
// it only while the block idles, as the block itself does not enforce it.
// A step runs on an element memory with one read and one write port: after
// the accepting cycle, two right-to-left scans, two swap writes, the tail
// reversal (read i, read j, write i, write j per pair), a start of the
// read-out, then a read and a load per result. A request with no successor
// sets up its single result in the accepting cycle for length 0 or 1, else
// once the first scan finds no ascent.
// s_ready is high only between requests; the result register holds while
// m_ready is low and the sequencer waits on it.
// Reset clears perm_length and the control state; the element memory is not
// cleared and must be loaded before it is stepped.

module next_lexicographic_permutation #(
    parameter int MAX_LEN    = nlp_pkg::DEF_MAX_LEN,
    parameter int VALUE_BITS = nlp_pkg::DEF_VALUE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nlp_pkg::ADDR_W-1:0]      paddr,
    input  logic [nlp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [nlp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [nlp_pkg::POS_W-1:0]       s_elem_index,
    input  logic [nlp_pkg::DATA_W-1:0]      s_elem_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nlp_pkg::POS_W-1:0]       m_out_position,
    output logic [nlp_pkg::DATA_W-1:0]      m_out_value,
    output logic                            m_last,
    output logic                            m_no_next
);

    logic [nlp_pkg::LEN_W-1:0] perm_length_reg;
    logic                      reg_hit;
    nlp_pkg::dp_op_t           op;
    nlp_pkg::dp_status_t       status;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[nlp_pkg::ADDR_W-1:2] == nlp_pkg::REG_PERM_LENGTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            perm_length_reg <= '0;
        end else if (psel && penable && pwrite && reg_hit) begin
            perm_length_reg <= pwdata[nlp_pkg::LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = nlp_pkg::APB_DATA_W'(perm_length_reg);
        end
    end

    nlp_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .status     (status),
        .op         (op),
        .s_ready    (s_ready)
    );

    nlp_datapath #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (op),
        .perm_length    (perm_length_reg),
        .s_elem_index   (s_elem_index),
        .s_elem_value   (s_elem_value),
        .m_ready        (m_ready),
        .status         (status),
        .m_valid        (m_valid),
        .m_out_position (m_out_position),
        .m_out_value    (m_out_value),
        .m_last         (m_last),
        .m_no_next      (m_no_next)
    );

endmodule

@@ rtl/core/nlp_ctrl.sv @@
`timescale 1ns / 1ps

module nlp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_req_type,
    input  nlp_pkg::dp_status_t    status,
    output nlp_pkg::dp_op_t        op,
    output logic                   s_ready
);

    nlp_pkg::ctrl_state_t state_reg;
    nlp_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nlp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = nlp_pkg::DP_NOP;
        s_ready    = 1'b0;
        case (state_reg)
            nlp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!s_req_type) begin
                        op = nlp_pkg::DP_LOAD;
                    end else if (status.len_le1) begin
                        op         = nlp_pkg::DP_DONE;
                        state_next = nlp_pkg::ST_DONE_WAIT;
                    end else begin
                        op         = nlp_pkg::DP_SCAN_INIT;
                        state_next = nlp_pkg::ST_SCAN1;
                    end
                end
            end
            nlp_pkg::ST_SCAN1: begin
                if (status.s1_exhaust) begin
                    op         = nlp_pkg::DP_DONE;
                    state_next = nlp_pkg::ST_DONE_WAIT;
                end else begin
                    op = nlp_pkg::DP_STEP1;
                    if (status.s1_found) begin
                        state_next = nlp_pkg::ST_SCAN2_INIT;
                    end
                end
            end
            nlp_pkg::ST_SCAN2_INIT: begin
                op         = nlp_pkg::DP_SCAN_INIT;
                state_next = nlp_pkg::ST_SCAN2;
            end
            nlp_pkg::ST_SCAN2: begin
                op = nlp_pkg::DP_STEP2;
                if (status.s2_found) begin
                    state_next = nlp_pkg::ST_SWAP_P;
                end
            end
            nlp_pkg::ST_SWAP_P: begin
                op         = nlp_pkg::DP_WR_P;
                state_next = nlp_pkg::ST_SWAP_Q;
            end
            nlp_pkg::ST_SWAP_Q: begin
                op         = nlp_pkg::DP_WR_Q;
                state_next = nlp_pkg::ST_REV_RD_I;
            end
            nlp_pkg::ST_REV_RD_I: begin
                // read the next pair while one remains; tail fully reversed: start emitting from position zero
                if (status.rev_more) begin
                    op         = nlp_pkg::DP_RD_I;
                    state_next = nlp_pkg::ST_REV_RD_J;
                end else begin
                    op         = nlp_pkg::DP_EMIT_INIT;
                    state_next = nlp_pkg::ST_EMIT_RD;
                end
            end
            nlp_pkg::ST_REV_RD_J: begin
                op         = nlp_pkg::DP_RD_J;
                state_next = nlp_pkg::ST_REV_WR_I;
            end
            nlp_pkg::ST_REV_WR_I: begin
                op         = nlp_pkg::DP_WR_I;
                state_next = nlp_pkg::ST_REV_WR_J;
            end
            nlp_pkg::ST_REV_WR_J: begin
                op         = nlp_pkg::DP_WR_J;
                state_next = nlp_pkg::ST_REV_RD_I;
            end
            nlp_pkg::ST_EMIT_RD: begin
                op         = nlp_pkg::DP_EMIT_RD;
                state_next = nlp_pkg::ST_EMIT_LD;
            end
            nlp_pkg::ST_EMIT_LD: begin
                op         = nlp_pkg::DP_EMIT_LD;
                state_next = nlp_pkg::ST_EMIT_WAIT;
            end
            nlp_pkg::ST_EMIT_WAIT: begin
                // keep reading the next element while the result is held
                op = nlp_pkg::DP_EMIT_RD;
                if (status.out_last_taken) begin
                    state_next = nlp_pkg::ST_IDLE;
                end else if (status.out_more_taken) begin
                    state_next = nlp_pkg::ST_EMIT_LD;
                end
            end
            nlp_pkg::ST_DONE_WAIT: begin
                if (status.out_last_taken) begin
                    state_next = nlp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nlp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/nlp_datapath.sv @@
`timescale 1ns / 1ps

module nlp_datapath #(
    parameter int MAX_LEN    = nlp_pkg::DEF_MAX_LEN,
    parameter int VALUE_BITS = nlp_pkg::DEF_VALUE_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  nlp_pkg::dp_op_t             op,
    input  logic [nlp_pkg::LEN_W-1:0]   perm_length,
    input  logic [nlp_pkg::POS_W-1:0]   s_elem_index,
    input  logic [nlp_pkg::DATA_W-1:0]  s_elem_value,
    input  logic                        m_ready,
    output nlp_pkg::dp_status_t         status,
    output logic                        m_valid,
    output logic [nlp_pkg::POS_W-1:0]   m_out_position,
    output logic [nlp_pkg::DATA_W-1:0]  m_out_value,
    output logic                        m_last,
    output logic                        m_no_next
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int IW = nlp_pkg::LEN_W;

    logic [VALUE_BITS-1:0] mem [MAX_LEN];

    logic [IW-1:0]         eff_len;
    logic [IW-1:0]         last_idx;

    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  wr_en;

    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [VALUE_BITS-1:0] prev_reg, prev_next;
    logic [VALUE_BITS-1:0] pv_reg, pv_next;
    logic [VALUE_BITS-1:0] qv_reg, qv_next;
    logic [VALUE_BITS-1:0] vi_reg, vi_next;
    logic [IW-1:0]         ridx_reg, ridx_next;
    logic [IW-1:0]         didx_reg, didx_next;
    logic [IW-1:0]         p_reg, p_next;
    logic [IW-1:0]         q_reg, q_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [IW-1:0]         j_reg, j_next;
    logic [1:0]            fill_reg, fill_next;

    logic                        m_valid_reg, m_valid_next;
    logic [nlp_pkg::POS_W-1:0]   m_pos_reg, m_pos_next;
    logic [nlp_pkg::DATA_W-1:0]  m_val_reg, m_val_next;
    logic                        m_last_reg, m_last_next;
    logic                        m_done_reg, m_done_next;

    logic                  out_fire;
    logic                  s1_cmp;
    logic                  ascent;

    // length in use saturates at the store depth
    always_comb begin
        if (int'(perm_length) > MAX_LEN) begin
            eff_len = IW'(MAX_LEN);
        end else begin
            eff_len = perm_length;
        end
        last_idx = IW'(eff_len - 1'b1);
    end

    assign out_fire = m_valid_reg && m_ready;
    assign s1_cmp   = (fill_reg == 2'd2);
    assign ascent   = (rd_data_reg < prev_reg);

    always_comb begin
        status.len_le1        = (eff_len <= IW'(1));
        status.s1_found       = s1_cmp && ascent;
        status.s1_exhaust     = s1_cmp && !ascent && (didx_reg == '0);
        status.s2_found       = (fill_reg != 2'd0) && (rd_data_reg > pv_reg);
        status.rev_more       = (i_reg < j_reg);
        status.out_last_taken = out_fire && m_last_reg;
        status.out_more_taken = out_fire && !m_last_reg;
    end

    always_comb begin
        prev_next    = prev_reg;
        pv_next      = pv_reg;
        qv_next      = qv_reg;
        vi_next      = vi_reg;
        ridx_next    = ridx_reg;
        didx_next    = didx_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        fill_next    = fill_reg;
        m_pos_next   = m_pos_reg;
        m_val_next   = m_val_reg;
        m_last_next  = m_last_reg;
        m_done_next  = m_done_reg;
        m_valid_next = m_valid_reg;
        rd_addr      = AW'(ridx_reg);
        wr_en        = 1'b0;
        wr_addr      = AW'(ridx_reg);
        wr_data      = rd_data_reg;

        if (out_fire) begin
            m_valid_next = 1'b0;
        end

        case (op)
            nlp_pkg::DP_LOAD: begin
                // drop loads at or beyond the length in use
                wr_en   = (IW'(s_elem_index) < eff_len);
                wr_addr = AW'(s_elem_index);
                wr_data = VALUE_BITS'(s_elem_value);
            end
            nlp_pkg::DP_SCAN_INIT: begin
                ridx_next = last_idx;
                fill_next = 2'd0;
            end
            nlp_pkg::DP_STEP1: begin
                ridx_next = ridx_reg - 1'b1;
                didx_next = ridx_reg;
                prev_next = rd_data_reg;
                fill_next = s1_cmp ? fill_reg : fill_reg + 1'b1;
                p_next    = didx_reg;
                pv_next   = rd_data_reg;
            end
            nlp_pkg::DP_STEP2: begin
                ridx_next = ridx_reg - 1'b1;
                didx_next = ridx_reg;
                fill_next = s1_cmp ? fill_reg : fill_reg + 1'b1;
                q_next    = didx_reg;
                qv_next   = rd_data_reg;
            end
            nlp_pkg::DP_WR_P: begin
                wr_en   = 1'b1;
                wr_addr = AW'(p_reg);
                wr_data = qv_reg;
            end
            nlp_pkg::DP_WR_Q: begin
                wr_en   = 1'b1;
                wr_addr = AW'(q_reg);
                wr_data = pv_reg;
                i_next  = p_reg + 1'b1;
                j_next  = last_idx;
            end
            nlp_pkg::DP_RD_I: begin
                rd_addr = AW'(i_reg);
            end
            nlp_pkg::DP_RD_J: begin
                rd_addr = AW'(j_reg);
                vi_next = rd_data_reg;
            end
            nlp_pkg::DP_WR_I: begin
                wr_en   = 1'b1;
                wr_addr = AW'(i_reg);
                wr_data = rd_data_reg;
            end
            nlp_pkg::DP_WR_J: begin
                wr_en   = 1'b1;
                wr_addr = AW'(j_reg);
                wr_data = vi_reg;
                i_next  = i_reg + 1'b1;
                j_next  = j_reg - 1'b1;
            end
            nlp_pkg::DP_EMIT_INIT: begin
                ridx_next = '0;
            end
            nlp_pkg::DP_EMIT_RD: begin
                rd_addr = AW'(ridx_reg);
            end
            nlp_pkg::DP_EMIT_LD: begin
                m_valid_next = 1'b1;
                m_pos_next   = nlp_pkg::POS_W'(ridx_reg);
                m_val_next   = nlp_pkg::DATA_W'(rd_data_reg);
                m_last_next  = (ridx_reg == last_idx);
                m_done_next  = 1'b0;
                ridx_next    = ridx_reg + 1'b1;
            end
            nlp_pkg::DP_DONE: begin
                m_valid_next = 1'b1;
                m_pos_next   = '0;
                m_val_next   = '0;
                m_last_next  = 1'b1;
                m_done_next  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            fill_reg    <= 2'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            fill_reg    <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg   <= prev_next;
        pv_reg     <= pv_next;
        qv_reg     <= qv_next;
        vi_reg     <= vi_next;
        ridx_reg   <= ridx_next;
        didx_reg   <= didx_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        m_pos_reg  <= m_pos_next;
        m_val_reg  <= m_val_next;
        m_last_reg <= m_last_next;
        m_done_reg <= m_done_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_position = m_pos_reg;
    assign m_out_value    = m_val_reg;
    assign m_last         = m_last_reg;
    assign m_no_next      = m_done_reg;

endmodule

@@ rtl/core/nlp_checker.sv @@
`timescale 1ns / 1ps
`include "next_lexicographic_permutation_defines.svh"

module nlp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [nlp_pkg::POS_W-1:0]      m_out_position,
    input logic [nlp_pkg::DATA_W-1:0]     m_out_value,
    input logic                           m_last,
    input logic                           m_no_next
);

    // a stalled result holds
    `NLP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_value) && $stable(m_out_position) && $stable(m_last))

    // no new request while results of the current one are pending
    `NLP_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_valid, !s_ready)

    // the no-successor result is a single, empty, final result
    `NLP_ASSERT_NOW(a_done_shape, aclk, aresetn, m_valid && m_no_next, m_last && (m_out_position == '0) && (m_out_value == '0))

    // taking the final result frees the input
    `NLP_ASSERT_NEXT(a_ready_after_last, aclk, aresetn, m_valid && m_ready && m_last, s_ready && !m_valid)

endmodule

bind next_lexicographic_permutation nlp_checker u_nlp_checker (.*);
